>>> rtl/obte_pkg.sv
package obte_pkg;

    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_DELETE  = 3'd1;
    localparam logic [2:0] CMD_EXECUTE = 3'd2;
    localparam logic [2:0] CMD_RESET   = 3'd3;
    localparam logic [2:0] CMD_BIDS    = 3'd4;
    localparam logic [2:0] CMD_ASKS    = 3'd5;

    localparam logic [3:0] ST_ADDED     = 4'd0;
    localparam logic [3:0] ST_MODIFIED  = 4'd1;
    localparam logic [3:0] ST_DELETED   = 4'd2;
    localparam logic [3:0] ST_PARTIAL   = 4'd3;
    localparam logic [3:0] ST_FULL_EXEC = 4'd4;
    localparam logic [3:0] ST_NOT_FOUND = 4'd5;
    localparam logic [3:0] ST_FULL      = 4'd6;
    localparam logic [3:0] ST_RESET     = 4'd7;
    localparam logic [3:0] ST_LEVEL     = 4'd8;
    localparam logic [3:0] ST_NO_LEVELS = 4'd9;

    localparam logic [39:0] QTY40_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [8:0]  CNT9_MAX  = 9'd511;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] order_key;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        logic        modify_quantity_only;
        logic [4:0]  level_depth;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] level_price;
        logic [39:0] level_quantity;
        logic [8:0]  level_orders;
        logic [8:0]  held_orders;
        logic        last;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture command, clear scan state
        logic scan;        // present entry at scan index (issue read)
        logic scan_first;  // restart index at zero
        logic step;        // evaluate returned entry
        logic pass_sum;    // current pass sums rather than finds best
        logic new_level;   // clear best/sum registers for next search pass
        logic write_hit;   // apply add/modify/delete/execute
        logic clear_table; // drop every valid bit
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;   // index reached last entry
        logic hit;         // key found
        logic free_found;  // a free slot exists
        logic best_found;  // a level was found in the search pass
        logic more_levels; // a worse price than the current level exists
    } dp_stat_t;

endpackage

>>> rtl/obte_ram.sv
module obte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/obte_datapath.sv
module obte_datapath #(
    parameter int TABLE_SIZE = 256,
    parameter int MAX_LEVELS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  obte_pkg::cmd_t      cmd_in,
    input  obte_pkg::dp_cmd_t   ctl,
    output obte_pkg::dp_stat_t  stat,
    output logic [2:0]          command,
    output logic [$clog2(MAX_LEVELS+1)-1:0] depth_limit,
    output obte_pkg::result_t   single_res,
    output obte_pkg::result_t   level_res
);
    import obte_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int LW = $clog2(MAX_LEVELS + 1);
    localparam int EW = 32 + 1 + 64;

    cmd_t            cmd_reg;
    logic [TABLE_SIZE-1:0] valid_reg;
    logic [8:0]      held_reg;
    logic [AW-1:0]   idx_reg;
    logic            rd_vld_reg;
    logic [AW-1:0]   rd_idx_reg;
    logic            hit_reg;
    logic [AW-1:0]   hit_idx_reg;
    logic            hit_sell_reg;
    logic            free_reg;
    logic [AW-1:0]   free_idx_reg;
    logic [63:0]     hit_pq_reg;
    logic            best_found_reg;
    logic [31:0]     best_reg;
    logic            more_reg;
    logic            have_prev_reg;
    logic [31:0]     prev_reg;
    logic [39:0]     sum_reg;
    logic [8:0]      cnt_reg;
    logic [3:0]      result_status;

    logic            we;
    logic [AW-1:0]   waddr;
    logic [EW-1:0]   wdata;
    logic [EW-1:0]   rdata;
    logic [31:0]     r_key;
    logic            r_sell;
    logic [63:0]     r_pq;
    logic            r_valid;
    logic [31:0]     r_price;
    logic            key_match;
    logic            side_ok;
    logic            q_sell;
    logic            lvl_side_ok;
    logic            cand;
    logic [40:0]     sum_wide;
    logic [8:0]      held_dec;

    assign r_key   = rdata[EW-1 -: 32];
    assign r_sell  = rdata[64];
    assign r_pq    = rdata[63:0];
    assign r_valid = valid_reg[rd_idx_reg];
    assign r_price = r_pq[63:32];
    assign key_match = r_valid && (r_key == cmd_reg.order_key);
    assign side_ok = (r_sell == cmd_reg.side);
    // level queries take their side from the command code
    assign q_sell = (cmd_reg.command == CMD_ASKS);
    assign lvl_side_ok = (r_sell == q_sell);
    assign cand = r_valid && lvl_side_ok &&
                  (!have_prev_reg || (q_sell ? (r_price > prev_reg)
                                             : (r_price < prev_reg)));
    assign sum_wide = {1'b0, sum_reg} + {9'd0, r_pq[31:0]};
    assign held_dec = (held_reg != 9'd0) ? held_reg - 9'd1 : held_reg;

    // Write port for the applied command
    always_comb begin
        we    = 1'b0;
        waddr = hit_idx_reg;
        wdata = {cmd_reg.order_key, cmd_reg.side, cmd_reg.price, cmd_reg.quantity};
        if (ctl.write_hit) begin
            case (cmd_reg.command)
                CMD_ADD: begin
                    if (hit_reg) begin
                        we = 1'b1;
                        if (cmd_reg.modify_quantity_only) begin
                            wdata = {cmd_reg.order_key, hit_sell_reg,
                                     hit_pq_reg[63:32], cmd_reg.quantity};
                        end
                    end else if (free_reg) begin
                        we    = 1'b1;
                        waddr = free_idx_reg;
                    end
                end
                CMD_EXECUTE: begin
                    we    = hit_reg && (cmd_reg.quantity < hit_pq_reg[31:0]);
                    wdata = {cmd_reg.order_key, cmd_reg.side, hit_pq_reg[63:32],
                             hit_pq_reg[31:0] - cmd_reg.quantity};
                end
                default: we = 1'b0;
            endcase
        end
    end

    obte_ram #(.WIDTH(EW), .DEPTH(TABLE_SIZE)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            held_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= ctl.scan;
            if (ctl.clear_table) begin
                valid_reg <= '0;
                held_reg  <= '0;
            end else if (ctl.write_hit) begin
                case (cmd_reg.command)
                    CMD_ADD: begin
                        if (!hit_reg && free_reg) begin
                            valid_reg[free_idx_reg] <= 1'b1;
                            held_reg <= (held_reg == CNT9_MAX) ? held_reg : held_reg + 9'd1;
                        end
                    end
                    CMD_DELETE: begin
                        if (hit_reg) begin
                            valid_reg[hit_idx_reg] <= 1'b0;
                            held_reg <= held_dec;
                        end
                    end
                    CMD_EXECUTE: begin
                        if (hit_reg && cmd_reg.quantity >= hit_pq_reg[31:0]) begin
                            valid_reg[hit_idx_reg] <= 1'b0;
                            held_reg <= held_dec;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg       <= cmd_in;
            have_prev_reg <= 1'b0;
        end
        // the entry presented now returns from the memory next cycle
        if (ctl.scan_first) begin
            idx_reg <= '0;
        end else if (ctl.scan && !stat.scan_done) begin
            idx_reg <= idx_reg + AW'(1);
        end
        if (ctl.scan) begin
            rd_idx_reg <= idx_reg;
        end
        if (ctl.load || ctl.new_level) begin
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            best_found_reg <= 1'b0;
            more_reg       <= 1'b0;
            sum_reg        <= '0;
            cnt_reg        <= '0;
        end else if (ctl.step && rd_vld_reg) begin
            if (!ctl.pass_sum) begin
                if (!hit_reg && key_match &&
                    (cmd_reg.command == CMD_ADD || side_ok)) begin
                    hit_reg      <= 1'b1;
                    hit_idx_reg  <= rd_idx_reg;
                    hit_pq_reg   <= r_pq;
                    hit_sell_reg <= r_sell;
                end
                if (!free_reg && !r_valid) begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
                if (cand && (!best_found_reg || (q_sell ? (r_price < best_reg)
                                                        : (r_price > best_reg)))) begin
                    best_found_reg <= 1'b1;
                    best_reg       <= r_price;
                end
            end else if (r_valid && lvl_side_ok) begin
                if (r_price == best_reg) begin
                    sum_reg <= sum_wide[40] ? QTY40_MAX : sum_wide[39:0];
                    cnt_reg <= (cnt_reg == CNT9_MAX) ? cnt_reg : cnt_reg + 9'd1;
                end
                if (q_sell ? (r_price > best_reg) : (r_price < best_reg)) begin
                    more_reg <= 1'b1;
                end
            end
        end
        if (ctl.write_hit) begin
            // level emitted: remember it as the bound for the next pass
            prev_reg      <= best_reg;
            have_prev_reg <= best_found_reg || have_prev_reg;
        end
    end

    // Single-result status
    always_comb begin
        result_status = ST_NOT_FOUND;
        case (cmd_reg.command)
            CMD_ADD:     result_status = hit_reg ? ST_MODIFIED :
                                         (free_reg ? ST_ADDED : ST_FULL);
            CMD_DELETE:  result_status = hit_reg ? ST_DELETED : ST_NOT_FOUND;
            CMD_EXECUTE: result_status = !hit_reg ? ST_NOT_FOUND :
                                         (cmd_reg.quantity >= hit_pq_reg[31:0]) ?
                                         ST_FULL_EXEC : ST_PARTIAL;
            CMD_RESET:   result_status = ST_RESET;
            default:     result_status = ST_NOT_FOUND;
        endcase
    end

    logic [8:0] held_after;
    always_comb begin
        held_after = held_reg;
        case (cmd_reg.command)
            CMD_ADD:     if (!hit_reg && free_reg && held_reg != CNT9_MAX)
                             held_after = held_reg + 9'd1;
            CMD_DELETE:  if (hit_reg) held_after = held_dec;
            CMD_EXECUTE: if (hit_reg && cmd_reg.quantity >= hit_pq_reg[31:0])
                             held_after = held_dec;
            CMD_RESET:   held_after = '0;
            default:     held_after = held_reg;
        endcase
    end

    always_comb begin
        single_res = '0;
        single_res.status      = result_status;
        single_res.held_orders = held_after;
        single_res.last        = 1'b1;
        level_res = '0;
        level_res.status         = best_found_reg ? ST_LEVEL : ST_NO_LEVELS;
        level_res.level_price    = best_found_reg ? best_reg : '0;
        level_res.level_quantity = best_found_reg ? sum_reg : '0;
        level_res.level_orders   = best_found_reg ? cnt_reg : '0;
        level_res.held_orders    = held_reg;
    end

    assign command = cmd_reg.command;
    assign depth_limit = (cmd_reg.level_depth == 5'd0 ||
                          32'(cmd_reg.level_depth) > MAX_LEVELS) ?
                         LW'(MAX_LEVELS) : LW'(cmd_reg.level_depth);

    assign stat.scan_done   = (idx_reg == AW'(TABLE_SIZE - 1));
    assign stat.hit         = hit_reg;
    assign stat.free_found  = free_reg;
    assign stat.best_found  = best_found_reg;
    assign stat.more_levels = more_reg;
endmodule

>>> rtl/obte_ctrl.sv
module obte_ctrl #(
    parameter int MAX_LEVELS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                out_level,
    output logic                out_last,
    input  logic [2:0]          command,
    input  logic [$clog2(MAX_LEVELS+1)-1:0] depth_limit,
    input  obte_pkg::dp_stat_t  stat,
    output obte_pkg::dp_cmd_t   ctl
);
    import obte_pkg::*;

    localparam int LW = $clog2(MAX_LEVELS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_APPLY = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [2:0] S_LOUT  = 3'd5;
    localparam logic [2:0] S_EVAL  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic          sum_reg, sum_next;
    logic [LW-1:0] lvl_reg, lvl_next;
    logic          query;
    logic          lvl_last;

    assign query    = (command == CMD_BIDS) || (command == CMD_ASKS);
    assign lvl_last = !stat.best_found || !stat.more_levels ||
                      (lvl_reg + LW'(1) >= depth_limit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sum_reg   <= 1'b0;
            lvl_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            lvl_reg   <= lvl_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sum_next   = sum_reg;
        lvl_next   = lvl_reg;
        ctl        = '0;
        ctl.pass_sum = sum_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        out_level  = 1'b0;
        out_last   = 1'b1;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    ctl.load   = 1'b1;
                    sum_next   = 1'b0;
                    lvl_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // restart the index at zero
                ctl.scan_first = 1'b1;
                state_next     = S_DRAIN;
            end
            S_DRAIN: begin
                ctl.step = 1'b1;
                ctl.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                // evaluate the final read
                ctl.step   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (!query) begin
                    state_next = S_OUT;
                end else if (!sum_reg && stat.best_found) begin
                    sum_next   = 1'b1;
                    state_next = S_SCAN;
                end else begin
                    state_next = S_LOUT;
                end
            end
            S_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    ctl.write_hit   = (command != CMD_RESET);
                    ctl.clear_table = (command == CMD_RESET);
                    state_next      = S_IDLE;
                end
            end
            S_LOUT: begin
                out_valid = 1'b1;
                out_level = 1'b1;
                out_last  = lvl_last;
                if (out_ready) begin
                    if (lvl_last) begin
                        state_next = S_IDLE;
                    end else begin
                        ctl.write_hit = 1'b1;
                        ctl.new_level = 1'b1;
                        sum_next      = 1'b0;
                        lvl_next      = lvl_reg + LW'(1);
                        state_next    = S_SCAN;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

>>> rtl/order_book_table_engine.sv
// Limit order book table engine.
// Input channel s_axis_*: one command per transfer (add/modify, delete,
// execute, reset, bid or ask level query). Result channel m_axis_*: one
// result per command, or one per price level for queries, best first;
// tlast marks the final result of a command.
// Each add, delete, execute or reset command scans the whole table once
// through the registered read port of the entry memory; the next command
// can be taken in the cycle after the result transfers. A level query
// takes two scans per emitted level (find best price, then sum it and
// look for a further level).
// One command is in work at a time; s_axis_tready is high only when idle.
// After reset the table is empty; entry memory contents are unused until
// written because a valid bit guards every entry.
// If the receiver stalls, the pending result holds on m_axis_tdata and
// the table update waits until that result transfers.
module order_book_table_engine #(
    parameter int TABLE_SIZE = 256,
    parameter int MAX_LEVELS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[2:0], order_key[34:3], side[35], price[67:36],
    // quantity[99:68], modify_quantity_only[100], level_depth[105:101]
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[3:0], level_price[35:4], level_quantity[75:36],
    // level_orders[84:76], held_orders[93:85]
    output logic [95:0]  m_axis_tdata,
    output logic         m_axis_tlast
);
    import obte_pkg::*;

    localparam int LW = $clog2(MAX_LEVELS + 1);

    cmd_t      cmd_in;
    dp_cmd_t   ctl;
    dp_stat_t  stat;
    logic [2:0] command;
    logic [LW-1:0] depth_limit;
    result_t   single_res, level_res, res;
    logic      out_level;
    logic      in_fire;

    assign cmd_in.command              = s_axis_tdata[2:0];
    assign cmd_in.order_key            = s_axis_tdata[34:3];
    assign cmd_in.side                 = s_axis_tdata[35];
    assign cmd_in.price                = s_axis_tdata[67:36];
    assign cmd_in.quantity             = s_axis_tdata[99:68];
    assign cmd_in.modify_quantity_only = s_axis_tdata[100];
    assign cmd_in.level_depth          = s_axis_tdata[105:101];

    assign in_fire = s_axis_tvalid && s_axis_tready;

    obte_ctrl #(.MAX_LEVELS(MAX_LEVELS)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .in_ready    (s_axis_tready),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_level   (out_level),
        .out_last    (m_axis_tlast),
        .command     (command),
        .depth_limit (depth_limit),
        .stat        (stat),
        .ctl         (ctl)
    );

    obte_datapath #(.TABLE_SIZE(TABLE_SIZE), .MAX_LEVELS(MAX_LEVELS)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_in      (cmd_in),
        .ctl         (ctl),
        .stat        (stat),
        .command     (command),
        .depth_limit (depth_limit),
        .single_res  (single_res),
        .level_res   (level_res)
    );

    assign res = out_level ? level_res : single_res;
    assign m_axis_tdata = {2'b00, res.held_orders, res.level_orders,
                           res.level_quantity, res.level_price, res.status};
endmodule
